// ===== design/nebs_pkg.sv =====
// ----------------------------------------------------------------------------
// nebs_pkg
// Shared types, constants and helpers for the nested event byte swapper.
// ----------------------------------------------------------------------------
package nebs_pkg;

    localparam int STACK_DEPTH_DEF = 16;
    localparam int POS_WIDTH_DEF   = 32;

    localparam logic [7:0] KIND_BANK    = 8'h10;
    localparam logic [7:0] KIND_SEG     = 8'h20;
    localparam logic [7:0] KIND_UNKNOWN = 8'hFF;
    localparam int         EVH_HALVES   = 4;

    typedef enum logic [2:0] {
        M_EVH, M_BANK, M_SEG, M_PACK, M_DATA
    } mode_t;

    typedef enum logic [2:0] {
        C_BAD, C_COPY, C_HALF, C_WORD, C_LONG
    } dclass_t;

    typedef enum logic [2:0] {
        S_IDLE, S_RD, S_CMP, S_PROC, S_EMIT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic rd;
        logic pop;
        logic set_hk;
        logic proc;
        logic adv;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan;
        logic top_match;
        logic more;
        logic hold;
        logic last;
    } dp_stat_t;

    function automatic logic [15:0] sw16(input logic [15:0] h);
        return {h[7:0], h[15:8]};
    endfunction

    function automatic dclass_t data_class(input logic [7:0] t);
        dclass_t c;
        case (t)
            8'h00, 8'h01, 8'h02, 8'h09, 8'h0F: c = C_WORD;
            8'h04, 8'h05, 8'h30, 8'h34, 8'h35: c = C_HALF;
            8'h03, 8'h06, 8'h07, 8'h36, 8'h37: c = C_COPY;
            8'h08, 8'h0A:                      c = C_LONG;
            default:                           c = C_BAD;
        endcase
        return c;
    endfunction

endpackage

// ===== design/nebs_ctrl.sv =====
// ----------------------------------------------------------------------------
// nebs_ctrl
// Sequencer: accept, stack pops, unit processing and result emission.
// ----------------------------------------------------------------------------
module nebs_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    input  nebs_pkg::dp_stat_t  stat,
    output nebs_pkg::ctrl_cmd_t cmd
);
    import nebs_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                    state_next = stat.scan ? S_RD : S_PROC;
            end
            S_RD:
                state_next = S_CMP;
            S_CMP:
            begin
                if (stat.top_match && stat.more)
                    state_next = S_RD;
                else
                    state_next = S_PROC;
            end
            S_PROC:
                state_next = stat.hold ? S_IDLE : S_EMIT;
            S_EMIT:
            begin
                if (m_tready && stat.last)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        m_tvalid = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            S_RD:
                cmd.rd = 1'b1;
            S_CMP:
            begin
                cmd.pop    = stat.top_match;
                cmd.set_hk = !stat.top_match;
            end
            S_PROC:
                cmd.proc = 1'b1;
            S_EMIT:
            begin
                m_tvalid = 1'b1;
                cmd.adv  = m_tready;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== design/nebs_dp.sv =====
// ----------------------------------------------------------------------------
// nebs_dp
// Datapath: position/header registers, nesting stack memory, unit assembly
// and the result buffer.
// ----------------------------------------------------------------------------
module nebs_dp
#(
    parameter int STACK_DEPTH = nebs_pkg::STACK_DEPTH_DEF,
    parameter int POS_WIDTH   = nebs_pkg::POS_WIDTH_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [15:0]         in_half,
    input  nebs_pkg::ctrl_cmd_t cmd,
    output nebs_pkg::dp_stat_t  stat,
    output logic [15:0]         out_half,
    output logic                last_of_run,
    output logic                event_end,
    output logic                bad_type
);
    import nebs_pkg::*;

    localparam int PW = POS_WIDTH;
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    logic [PW-1:0] pos_reg, total_reg, nha_reg;
    logic [7:0]    hk_reg, dk_reg;
    logic [CW-1:0] cnt_reg;
    logic [47:0]   held_reg;
    logic [1:0]    hc_reg;
    logic [15:0]   x_reg;

    logic [PW-1:0] mem_end [STACK_DEPTH];
    logic [7:0]    mem_kind [STACK_DEPTH];
    logic [PW-1:0] rd_end_reg;
    logic [7:0]    rd_kind_reg;

    logic [15:0] ob_reg [4];
    logic        ob_bad_reg;
    logic [2:0]  n_reg;
    logic [1:0]  idx_reg;
    logic        ends_reg;

    // unit processing, combinational
    logic [PW-1:0] start, nxt, tot, endp, nha_n, total_n, push_end;
    logic [7:0]    hk_n, dk_n, kind, push_kind;
    logic [CW-1:0] cnt_n;
    logic [2:0]    k, size, m, n_n;
    logic [15:0]   h [4];
    logic [15:0]   ob_n [4];
    logic [31:0]   w0, w1;
    logic [32:0]   t33;
    logic [17:0]   s18;
    logic [15:0]   p;
    mode_t         mode;
    dclass_t       cls;
    logic          done, ends, bad, do_push, push_ok;

    always_comb
    begin
        nxt   = pos_reg + PW'(1);
        start = pos_reg - PW'(hc_reg);
        cls   = data_class(dk_reg);
        if (start < PW'(EVH_HALVES))
        begin
            mode = M_EVH;  size = 3'd4;
        end
        else if (start == nha_reg)
        begin
            if (hk_reg == KIND_BANK)     begin mode = M_BANK; size = 3'd4; end
            else if (hk_reg == KIND_SEG) begin mode = M_SEG;  size = 3'd2; end
            else                         begin mode = M_PACK; size = 3'd1; end
        end
        else
        begin
            mode = M_DATA;
            size = (cls == C_WORD) ? 3'd2 : (cls == C_LONG) ? 3'd4 : 3'd1;
        end
        k    = {1'b0, hc_reg} + 3'd1;
        ends = (nxt == total_reg);
        done = (k >= size) || (mode != M_EVH && ends) ||
               (mode == M_DATA && nxt == nha_reg);

        h[0] = held_reg[15:0];
        h[1] = held_reg[31:16];
        h[2] = held_reg[47:32];
        h[3] = 16'h0;
        h[hc_reg] = x_reg;

        w0  = {sw16(h[0]), sw16((k == 3'd1) ? h[0] : h[1])};
        w1  = {sw16(h[2]), sw16(h[3])};
        t33 = {w0 + 32'd1, 1'b0};
        s18 = {({1'b0, w0[15:0]} + 17'd1), 1'b0};
        p   = sw16(h[0]);
        tot = t33[PW-1:0];

        total_n   = total_reg;
        nha_n     = nha_reg;
        hk_n      = hk_reg;
        dk_n      = dk_reg;
        cnt_n     = cnt_reg;
        bad       = 1'b0;
        do_push   = 1'b0;
        push_ok   = (cnt_reg < CW'(STACK_DEPTH));
        push_end  = '0;
        push_kind = '0;
        endp      = '0;
        kind      = '0;

        // header decode
        if (k == size && mode != M_DATA)
        begin
            case (mode)
                M_EVH:
                begin
                    total_n = (tot < PW'(EVH_HALVES)) ? PW'(EVH_HALVES) : tot;
                    kind    = w1[15:8];
                    hk_n    = kind;
                    cnt_n   = '0;
                    if (kind >= KIND_BANK)
                    begin
                        do_push   = 1'b1;
                        push_ok   = 1'b1;
                        push_end  = total_n;
                        push_kind = kind;
                        cnt_n     = CW'(1);
                        nha_n     = PW'(EVH_HALVES);
                        dk_n      = 8'h00;
                    end
                    else
                    begin
                        nha_n = total_n;
                        dk_n  = kind;
                    end
                end
                M_BANK, M_SEG:
                begin
                    if (mode == M_BANK)
                    begin
                        endp = start + t33[PW-1:0];
                        kind = w1[15:8];
                    end
                    else
                    begin
                        endp = start + PW'(s18);
                        kind = w0[23:16];
                    end
                    if ((mode == M_BANK && kind >= KIND_BANK) ||
                        (mode == M_SEG && kind >= KIND_SEG))
                    begin
                        if (push_ok)
                        begin
                            do_push   = 1'b1;
                            push_end  = endp;
                            push_kind = kind;
                            cnt_n     = cnt_reg + CW'(1);
                            nha_n     = start + ((mode == M_BANK) ? PW'(4) : PW'(2));
                        end
                        else
                        begin
                            bad   = 1'b1;
                            dk_n  = KIND_UNKNOWN;
                            nha_n = endp;
                        end
                    end
                    else
                    begin
                        dk_n  = kind;
                        nha_n = endp;
                    end
                end
                M_PACK:
                begin
                    nha_n = start + PW'({1'b0, p[7:0]} + 9'd1);
                    if (p != 16'h0)
                        dk_n = hk_reg;
                end
                default:
                begin
                    nha_n = nha_reg;
                end
            endcase
        end

        // event end is checked against the length just decoded
        ends = (nxt == total_n);

        // result words
        m = (k < 3'd2) ? k : 3'd2;
        for (int i = 0; i < 4; i++)
        begin
            ob_n[i] = 16'h0;
            if (mode == M_PACK)
                ob_n[i] = sw16(h[0]);
            else if (mode == M_DATA)
            begin
                if (cls == C_COPY || cls == C_BAD)
                    ob_n[i] = h[i];
                else
                    ob_n[i] = sw16(h[2'(hc_reg - 2'(i))]);
            end
            else if (3'(i) < m)
                ob_n[i] = sw16(h[2'(m - 3'd1 - 3'(i))]);
            else
                ob_n[i] = sw16(h[2'(hc_reg - 2'(i - 2))]);
        end
        n_n = k;
    end

    assign stat.scan      = (hc_reg == 2'd0) && (pos_reg >= PW'(EVH_HALVES)) &&
                            (cnt_reg != '0);
    assign stat.top_match = (rd_end_reg == pos_reg) && (cnt_reg != '0);
    assign stat.more      = (cnt_reg > CW'(1));
    assign stat.hold      = !done;
    assign stat.last      = ({1'b0, idx_reg} == n_reg - 3'd1);

    assign out_half    = ob_reg[idx_reg];
    assign last_of_run = stat.last;
    assign event_end   = stat.last && ends_reg;
    assign bad_type    = ob_bad_reg;

    // nesting stack memory
    always_ff @(posedge clk)
    begin
        if (cmd.rd)
        begin
            rd_end_reg  <= mem_end[AW'(cnt_reg - CW'(1))];
            rd_kind_reg <= mem_kind[AW'(cnt_reg - CW'(1))];
        end
        if (cmd.proc && done && do_push && push_ok)
        begin
            mem_end[(mode == M_EVH) ? AW'(0) : AW'(cnt_reg)]  <= push_end;
            mem_kind[(mode == M_EVH) ? AW'(0) : AW'(cnt_reg)] <= push_kind;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
            x_reg <= in_half;
        if (cmd.proc && done)
        begin
            for (int i = 0; i < 4; i++)
                ob_reg[i] <= ob_n[i];
            ob_bad_reg <= bad || (mode == M_DATA && cls == C_BAD);
            n_reg      <= n_n;
            ends_reg   <= ends;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            total_reg <= '0;
            nha_reg   <= '0;
            hk_reg    <= '0;
            dk_reg    <= '0;
            cnt_reg   <= '0;
            held_reg  <= '0;
            hc_reg    <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            if (cmd.pop)
                cnt_reg <= cnt_reg - CW'(1);
            if (cmd.set_hk && pos_reg == nha_reg && cnt_reg != '0)
                hk_reg <= rd_kind_reg;
            if (cmd.adv)
                idx_reg <= idx_reg + 2'd1;
            if (cmd.proc)
            begin
                if (!done)
                begin
                    case (hc_reg)
                        2'd0:    held_reg[15:0]  <= x_reg;
                        2'd1:    held_reg[31:16] <= x_reg;
                        default: held_reg[47:32] <= x_reg;
                    endcase
                    hc_reg  <= hc_reg + 2'd1;
                    pos_reg <= nxt;
                end
                else
                begin
                    total_reg <= total_n;
                    nha_reg   <= nha_n;
                    hk_reg    <= hk_n;
                    dk_reg    <= dk_n;
                    held_reg  <= '0;
                    hc_reg    <= '0;
                    idx_reg   <= '0;
                    if (ends)
                    begin
                        pos_reg <= '0;
                        cnt_reg <= '0;
                    end
                    else
                    begin
                        pos_reg <= nxt;
                        cnt_reg <= cnt_n;
                    end
                end
            end
        end
    end

endmodule

// ===== design/nested_event_byte_swapper.sv =====
// ----------------------------------------------------------------------------
// nested_event_byte_swapper
// Byte-order converter for one nested event, one halfword per input word.
// ----------------------------------------------------------------------------
// Channel   Dir  tdata          tuser                 tlast
// s_        in   in_half[15:0]  -                     -
// m_        out  out_half[15:0] event_end, bad_type   last_of_run
//
// An input word is accepted and then processed, with a stack top read and
// compare in between whenever a unit starts while a container is open,
// repeated for each extra nesting level closed there; each result word (0
// to 4) is then emitted. Input is taken only when the previous word's results
// are all delivered. Reset clears position, counters and the stack count;
// stack entries are never read before being written.
module nested_event_byte_swapper
#(
    parameter int STACK_DEPTH = nebs_pkg::STACK_DEPTH_DEF,
    parameter int POS_WIDTH   = nebs_pkg::POS_WIDTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] in_half
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] out_half
    output logic        m_tlast,
    output logic [1:0]  m_tuser    // [0] event_end, [1] bad_type
);
    import nebs_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    nebs_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    nebs_dp
    #(
        .STACK_DEPTH (STACK_DEPTH),
        .POS_WIDTH   (POS_WIDTH)
    )
    u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_half     (s_tdata),
        .cmd         (cmd),
        .stat        (stat),
        .out_half    (m_tdata),
        .last_of_run (m_tlast),
        .event_end   (m_tuser[0]),
        .bad_type    (m_tuser[1])
    );

endmodule
